// ----- rtl/mpq_pkg.sv -----
// Shared constants, types and the reset scale for the pitch quantizer.
package mpq_pkg;

	localparam int MAX_NOTES = 16;
	localparam int IDX_W = $clog2(MAX_NOTES);
	localparam int CNT_W = 5;
	localparam int CENTS_W = 29;
	localparam int VOLT_W = 21;
	localparam int DIV_W = 32;
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_STEPS = DIV_W / DIV_RADIX_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;

	localparam int RESET_COUNT = 12;
	localparam int CENTS_PER_STEP = 100 * 65536;
	localparam int CENTS_PER_VOLT = 1200;
	localparam int HALF_VOLT_DIV = CENTS_PER_VOLT / 2;
	localparam int VOLT_MAX_MAG = 786431;
	localparam int VOLT_MIN_MAG = 786432;

	// divide by 1200 as a shift by 4 and a multiply by the rounded-up reciprocal of 75;
	// exact for every dividend below 2^31
	localparam int RECIP_PRE = 4;
	localparam int RECIP_W = 28;
	localparam int RECIP_SHIFT = 34;
	localparam logic [RECIP_W-1:0] RECIP_75 = RECIP_W'(229064923);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [CENTS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
		logic [CENTS_W-1:0] remainder;
	} div_rsp_t;

	// 12-tone equal temperament: entry i holds (i+1)*100 cents, later entries 0
	function automatic logic signed [CENTS_W-1:0] reset_cents(input logic [IDX_W-1:0] idx);
		int v;
		v = (int'(idx) < RESET_COUNT) ? (int'(idx) + 1) * CENTS_PER_STEP : 0;
		return CENTS_W'(v);
	endfunction

endpackage

// ----- rtl/microtonal_pitch_quantizer_unit.sv -----
// Top level of the pitch quantizer: snaps a pitch voltage to the nearest note of a cents scale.
// Sequence: a load item leaves the block ready again at once; a sample item reaches the
//   output register through the period read, the divider wait, the quotient fix, a scan
//   of the active entries, then the multiply, sum, volts and output steps.
// Flow: one sample item at a time; the next item is taken
//   once the sequencer is idle, even while the last result waits in the output register.
// Reset (arst_n low): scale_count returns to 12, every table entry reads as 12-TET again.
module microtonal_pitch_quantizer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// item in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [20:0] pitch_volts, [24:21] entry_index, [53:25] entry_cents, [55:54] zero
	input  logic [mpq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [0] op
	input  logic                            s_axis_tuser,
	// result out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [20:0] quantized_volts, [23:21] zero
	output logic [mpq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// scale_count register
	input  logic                            cfg_we,
	input  logic [mpq_pkg::CNT_W-1:0]       cfg_wdata
);
	import mpq_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PER  = 9'b000000010,
		ST_DIV1 = 9'b000000100,
		ST_FIX  = 9'b000001000,
		ST_SCAN = 9'b000010000,
		ST_MUL  = 9'b000100000,
		ST_SUM  = 9'b001000000,
		ST_VOLT = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	// input unpacking
	logic signed [VOLT_W-1:0]  in_pitch;
	logic [IDX_W-1:0]          in_index;
	logic signed [CENTS_W-1:0] in_cents;
	logic                      in_accept;

	assign in_pitch  = s_axis_tdata[VOLT_W-1:0];
	assign in_index  = s_axis_tdata[VOLT_W+IDX_W-1:VOLT_W];
	assign in_cents  = s_axis_tdata[VOLT_W+IDX_W+CENTS_W-1:VOLT_W+IDX_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// configuration register
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(RESET_COUNT);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// clamp the active count to the table size
	assign n_eff = (count_q > CNT_W'(MAX_NOTES)) ? CNT_W'(MAX_NOTES) : count_q;

	// scale table: RAM plus one written flag per entry; unwritten entries read as 12-TET
	logic [MAX_NOTES-1:0]      written_q;
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_raddr;
	logic [CENTS_W-1:0]        ram_rdata;
	logic [IDX_W-1:0]          raddr_s1;
	logic signed [CENTS_W-1:0] entry_rd;

	assign ram_we = in_accept && (s_axis_tuser == OP_LOAD);

	mpq_ram #(
		.WIDTH(CENTS_W),
		.DEPTH(MAX_NOTES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_index),
		.wdata(in_cents),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[in_index] <= 1'b1;
		end
	end

	// entry that the registered read returns this cycle
	assign entry_rd = written_q[raddr_s1] ? $signed(ram_rdata) : reset_cents(raddr_s1);

	// working registers
	logic [CNT_W-1:0]          n_q;
	logic signed [VOLT_W-1:0]  pitch_q;
	logic                      neg_q;
	logic [CENTS_W-1:0]        period_q;
	logic signed [DIV_W-1:0]   quo_q;
	logic [CENTS_W-1:0]        rem_q;
	logic signed [CENTS_W-1:0] best_q;
	logic [CENTS_W:0]          bestd_q;
	logic [CNT_W-1:0]          scan_q;
	logic                      cmp_s1;
	logic signed [DIV_W-1:0]   prod_q;
	logic [DIV_W-1:0]          rnd_q;
	logic [VOLT_W:0]           vq_q;
	logic                      m_valid_q;
	logic [VOLT_W-1:0]         m_data_q;

	logic                      scan_issue;
	logic signed [DIV_W-1:0]   cents_w;
	logic [DIV_W-1:0]          cents_mag;
	logic signed [CENTS_W+1:0] diff_w;
	logic [CENTS_W:0]          dist_w;
	logic signed [61:0]        prod_w;
	logic signed [DIV_W-1:0]   sum_w;
	logic [DIV_W-1:0]          sum_mag;
	logic [DIV_W-RECIP_PRE+RECIP_W-1:0] rcp_prod;
	logic [VOLT_W-1:0]         sat_w;
	logic                      out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	mpq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// read the period while waiting in the first state, then walk the entries in order
	assign scan_issue = (state_q == ST_SCAN) && (scan_q < n_q);

	always_comb begin
		if (state_q == ST_IDLE) begin
			ram_raddr = IDX_W'(n_eff - 1'b1);
		end else begin
			ram_raddr = scan_q[IDX_W-1:0];
		end
	end

	// volts to cents, signed magnitude for the divider
	assign cents_w   = DIV_W'(pitch_q) * DIV_W'(CENTS_PER_VOLT);
	assign cents_mag = cents_w[DIV_W-1] ? DIV_W'(-cents_w) : cents_w;

	// distance from the remainder to the entry just read
	assign diff_w = $signed({2'b00, rem_q}) - (CENTS_W+2)'(entry_rd);
	assign dist_w = diff_w[CENTS_W+1] ? (CENTS_W+1)'(-diff_w) : (CENTS_W+1)'(diff_w);

	// rebuild cents: q * period + best
	assign prod_w  = quo_q * $signed({1'b0, period_q});
	assign sum_w   = prod_q + DIV_W'(best_q);
	assign sum_mag = sum_w[DIV_W-1] ? DIV_W'(-sum_w) : sum_w;

	// rounded magnitude over 1200: drop four bits, then scale by the reciprocal of 75
	assign rcp_prod = rnd_q[DIV_W-1:RECIP_PRE] * RECIP_75;

	// sign and saturate the rounded volts
	always_comb begin
		if (neg_q) begin
			if (vq_q > (VOLT_W+1)'(VOLT_MIN_MAG)) begin
				sat_w = VOLT_W'(-VOLT_MIN_MAG);
			end else begin
				sat_w = VOLT_W'(-vq_q);
			end
		end else begin
			if (vq_q > (VOLT_W+1)'(VOLT_MAX_MAG)) begin
				sat_w = VOLT_W'(VOLT_MAX_MAG);
			end else begin
				sat_w = vq_q[VOLT_W-1:0];
			end
		end
	end

	// divider request: cents by period
	always_comb begin
		div_req = '0;
		if (state_q == ST_PER && !entry_rd[CENTS_W-1] && entry_rd != '0) begin
			div_req.start    = 1'b1;
			div_req.dividend = cents_mag;
			div_req.divisor  = entry_rd;
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmp_s1  <= 1'b0;
		end else begin
			cmp_s1 <= scan_issue;
			case (state_q)
				ST_IDLE: begin
					// drop samples with too few active entries
					if (in_accept && s_axis_tuser == OP_SAMPLE && n_eff >= CNT_W'(2)) begin
						state_q <= ST_PER;
					end
				end
				ST_PER: begin
					// drop samples whose period is not positive
					state_q <= div_req.start ? ST_DIV1 : ST_IDLE;
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (!scan_issue && !cmp_s1) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_VOLT;
				ST_VOLT: state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		raddr_s1 <= ram_raddr;
		case (state_q)
			ST_IDLE: begin
				pitch_q <= in_pitch;
				n_q     <= n_eff;
			end
			ST_PER: begin
				neg_q    <= cents_w[DIV_W-1];
				period_q <= entry_rd;
			end
			ST_FIX: begin
				// floor the quotient for negative cents
				if (neg_q) begin
					if (div_rsp.remainder != '0) begin
						quo_q <= DIV_W'(-div_rsp.quotient) - 1'b1;
						rem_q <= period_q - div_rsp.remainder;
					end else begin
						quo_q <= DIV_W'(-div_rsp.quotient);
						rem_q <= '0;
					end
				end else begin
					quo_q <= div_rsp.quotient;
					rem_q <= div_rsp.remainder;
				end
				scan_q <= '0;
			end
			ST_SCAN: begin
				if (scan_issue) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			ST_MUL: prod_q <= prod_w[DIV_W-1:0];
			ST_SUM: begin
				// halves round away from zero on the magnitude
				neg_q <= sum_w[DIV_W-1];
				rnd_q <= sum_mag + DIV_W'(HALF_VOLT_DIV);
			end
			ST_VOLT: vq_q <= rcp_prod[RECIP_SHIFT+VOLT_W:RECIP_SHIFT];
			default: ;
		endcase

		// nearest search: implicit root first, only a strictly smaller distance wins
		if (state_q == ST_FIX) begin
			best_q <= '0;
			if (neg_q && div_rsp.remainder != '0) begin
				bestd_q <= {1'b0, period_q - div_rsp.remainder};
			end else begin
				bestd_q <= {1'b0, div_rsp.remainder};
			end
		end else if (state_q == ST_SCAN && cmp_s1 && dist_w < bestd_q) begin
			bestd_q <= dist_w;
			best_q  <= entry_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= sat_w;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W - VOLT_W)'(0), m_data_q};

endmodule

// ----- rtl/mpq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/mpq_div.sv -----
// Iterative restoring divider, two quotient bits per cycle.
module mpq_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mpq_pkg::div_req_t   req,
	output mpq_pkg::div_rsp_t   rsp
);
	import mpq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [CENTS_W-1:0]   rem_q;
	logic [CENTS_W-1:0]   dvs_q;
	logic [DIV_W-1:0]     quo_nx;
	logic [CENTS_W-1:0]   rem_nx;

	// shift one dividend bit in, subtract where the divisor fits
	always_comb begin
		logic [CENTS_W:0] t;
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int k = 0; k < DIV_RADIX_BITS; k++) begin
			t = {rem_nx, quo_nx[DIV_W-1]};
			if (t >= {1'b0, dvs_q}) begin
				rem_nx = CENTS_W'(t - {1'b0, dvs_q});
				quo_nx = {quo_nx[DIV_W-2:0], 1'b1};
			end else begin
				rem_nx = t[CENTS_W-1:0];
				quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- rtl/mpq_checker.sv -----
// Port-level checks for the pitch quantizer, bound to the top level.
module mpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mpq_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import mpq_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// the block is ready again in the cycle after it takes a load item
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
		else $error("not ready after a load item");

	// the padding above the result stays zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:VOLT_W] == '0)
		else $error("padding bits set in a result");

endmodule

bind microtonal_pitch_quantizer_unit mpq_checker u_mpq_checker (.*);

// ----- dv/mpq_snap_checker.sv -----
// Scoreboard for the pitch quantizer: predicts each snapped voltage and checks the results.
module mpq_snap_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [mpq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [mpq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [mpq_pkg::CNT_W-1:0]      cfg_wdata,
	output int                             fault_count,
	output int                             pending
);
	import mpq_pkg::*;

	logic signed [CENTS_W-1:0] scale_cents [MAX_NOTES];
	logic [CNT_W-1:0] note_count;
	logic [VOLT_W-1:0] snap_due [$];

	// nearest scale note to the pitch; returns 0 when the scale cannot produce a note
	function automatic bit snap_pitch(input logic [VOLT_W-1:0] volts,
			output logic [VOLT_W-1:0] snapped);
		int n;
		longint period, cents, q, rem, best, best_d, d, res;
		n = (note_count > MAX_NOTES) ? MAX_NOTES : int'(note_count);
		if (n < 2)
			return 0;
		period = longint'(scale_cents[n-1]);
		if (period <= 0)
			return 0;
		cents = longint'($signed(volts)) * CENTS_PER_VOLT;
		q = cents / period;
		if ((cents % period) != 0 && cents < 0)
			q = q - 1;
		rem = cents - q * period;
		best = 0;
		best_d = (rem < 0) ? -rem : rem;
		for (int i = 0; i < n; i++) begin
			d = rem - longint'(scale_cents[i]);
			if (d < 0)
				d = -d;
			if (d < best_d) begin
				best_d = d;
				best = longint'(scale_cents[i]);
			end
		end
		res = q * period + best;
		if (res >= 0)
			res = (res + HALF_VOLT_DIV) / CENTS_PER_VOLT;
		else
			res = -((-res + HALF_VOLT_DIV) / CENTS_PER_VOLT);
		if (res < -longint'(VOLT_MIN_MAG))
			res = -longint'(VOLT_MIN_MAG);
		if (res > longint'(VOLT_MAX_MAG))
			res = longint'(VOLT_MAX_MAG);
		snapped = res[VOLT_W-1:0];
		return 1;
	endfunction

	task automatic log_fault(input string what);
		if (fault_count < 10)
			$display("%s", what);
		fault_count++;
	endtask

	initial begin
		fault_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		logic [VOLT_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_NOTES; i++)
				scale_cents[i] = (i < RESET_COUNT) ? CENTS_W'((i + 1) * CENTS_PER_STEP) : '0;
			note_count = CNT_W'(RESET_COUNT);
			snap_due.delete();
			pending = 0;
		end else begin
			// results first: a result never belongs to the item taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (snap_due.size() == 0) begin
					log_fault($sformatf("unexpected result: quantized_volts %0d",
						$signed(m_axis_tdata[VOLT_W-1:0])));
				end else begin
					want = snap_due.pop_front();
					if (m_axis_tdata[VOLT_W-1:0] !== want)
						log_fault($sformatf("quantized_volts: expected %0d, got %0d",
							$signed(want), $signed(m_axis_tdata[VOLT_W-1:0])));
				end
			end
			if (cfg_we)
				note_count = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == OP_LOAD)
					scale_cents[s_axis_tdata[24:21]] = s_axis_tdata[53:25];
				else if (snap_pitch(s_axis_tdata[VOLT_W-1:0], want))
					snap_due.insert(snap_due.size(), want);
			end
			pending = snap_due.size();
		end
	end

endmodule

// ----- dv/tb_microtonal_pitch_quantizer_unit.sv -----
// Testbench top for the pitch quantizer: drives items and scale settings, gives the verdict.
module tb_microtonal_pitch_quantizer_unit;
	import mpq_pkg::*;

	// hard stop for a hung run, well above the slowest legal run
	localparam int LIMIT_CYCLES = 1500000;
	// allow a sample item to finish before touching the register
	localparam int SETTLE_CYCLES = 80;
	// long receiver hold-off, enough to back the block up into its input
	localparam int HOLD_CYCLES = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [20:0] pitch_volts, [24:21] entry_index, [53:25] entry_cents, [55:54] zero
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	// [0] op
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// [20:0] quantized_volts, [23:21] zero
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_we;
	logic [CNT_W-1:0]      cfg_wdata;

	int fault_count;
	int pending;
	int cycle_count;
	bit gapless = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	microtonal_pitch_quantizer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	mpq_snap_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fault_count   (fault_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: count cycles and give up if the run hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Sender gap: mostly back to back, some short gaps, a few long ones.
	// Phases marked gapless give stretches with no idling at all.
	function automatic int pick_gap();
		int r;
		if (gapless)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// Pitch mix: the full input range, a band around zero, and the two saturating edges.
	function automatic logic [VOLT_W-1:0] pick_volts();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 60)
			v = int'($urandom_range(0, VOLT_MAX_MAG + VOLT_MIN_MAG)) - VOLT_MIN_MAG;
		else if (r < 85)
			v = int'($urandom_range(0, 10000)) - 5000;
		else if ($urandom_range(0, 1) == 0)
			v = VOLT_MAX_MAG - int'($urandom_range(0, 50));
		else
			v = int'($urandom_range(0, 50)) - VOLT_MIN_MAG;
		return VOLT_W'(v);
	endfunction

	// Note values: mostly musical (within an octave or so), some full-range noise, some tiny
	// values and the extremes. Keep the period mostly positive so samples keep producing results.
	function automatic logic signed [CENTS_W-1:0] pick_cents(input bit is_period);
		int r;
		logic signed [CENTS_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 55)
			c = CENTS_W'($urandom_range(0, 1300 * 65536));
		else if (r < 75)
			c = CENTS_W'($urandom);
		else if (r < 90)
			c = CENTS_W'(int'($urandom_range(0, 4000)) - 2000);
		else begin
			r = $urandom_range(0, 3);
			if (r == 0)
				c = {1'b1, {(CENTS_W-1){1'b0}}};
			else if (r == 1)
				c = {1'b0, {(CENTS_W-1){1'b1}}};
			else if (r == 2)
				c = '0;
			else
				c = CENTS_W'(1);
		end
		if (is_period && c <= 0 && $urandom_range(0, 99) < 85)
			c = CENTS_W'($urandom_range(1, 268435455));
		return c;
	endfunction

	// Offer one item from the falling edge, hold it until taken, then idle as chosen.
	task automatic send_item(input logic op, input logic [VOLT_W-1:0] volts,
			input logic [IDX_W-1:0] idx, input logic [CENTS_W-1:0] cents);
		int gap;
		s_axis_tuser = op;
		// unused fields carry random content; the two top bits are padding
		s_axis_tdata = {2'b00, cents, idx, volts};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		gap = pick_gap();
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_sample(input logic [VOLT_W-1:0] volts);
		send_item(OP_SAMPLE, volts, IDX_W'($urandom), CENTS_W'($urandom));
	endtask

	task automatic send_load(input logic [IDX_W-1:0] idx, input logic [CENTS_W-1:0] cents);
		send_item(OP_LOAD, VOLT_W'($urandom), idx, cents);
	endtask

	// Mostly samples; a good share of loads go to the period entry so the scale keeps moving.
	task automatic random_item(input int eff);
		int r;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			send_sample(pick_volts());
		end else begin
			idx = (r < 80 && eff >= 2) ? IDX_W'(eff - 1) : IDX_W'($urandom_range(0, MAX_NOTES - 1));
			send_load(idx, pick_cents(eff >= 2 && int'(idx) == eff - 1));
		end
	endtask

	// Drop valid, wait until every predicted result is out, then let a silent sample finish.
	task automatic drain_and_settle();
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_note_count(input int val);
		cfg_wdata = CNT_W'(val);
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Receiver: random stalls, quiet stretches with tready held high, and one long hold-off
	// requested by the stimulus while the sender keeps offering.
	initial begin : sink
		int gap_left;
		int quiet_left;
		int r;
		m_axis_tready = 1'b0;
		gap_left = 0;
		quiet_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (quiet_left != 0) begin
				m_axis_tready = 1'b1;
				quiet_left--;
			end else if (gap_left != 0) begin
				m_axis_tready = 1'b0;
				gap_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					quiet_left = $urandom_range(30, 150);
				else if (r < 8)
					gap_left = $urandom_range(20, 60);
				else if (r < 35)
					gap_left = $urandom_range(1, 3);
				m_axis_tready = (gap_left == 0);
				if (gap_left != 0)
					gap_left--;
			end
		end
	end

	initial begin : stimulus
		int plan [10];
		int eff;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_SAMPLE;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on the reset scale (12 notes, period 1200 cents).
		send_sample(VOLT_W'(0));
		// top of range lands on the next octave and must saturate
		send_sample(VOLT_W'(VOLT_MAX_MAG));
		send_sample(VOLT_W'(-VOLT_MIN_MAG));
		send_sample(VOLT_W'(1));
		send_sample(VOLT_W'(-1));
		// exactly halfway between 100 and 200 cents: the earlier entry wins
		send_sample(VOLT_W'(8192));
		// halfway between the root and the first entry: the root wins
		send_load(IDX_W'(0), CENTS_W'(2400));
		send_sample(VOLT_W'(1));
		// rebuilt cents of +600 raw: half rounds away from zero, upwards
		send_load(IDX_W'(0), CENTS_W'(600));
		send_sample(VOLT_W'(1));
		// rebuilt cents of -600 raw: half rounds away from zero, downwards
		send_load(IDX_W'(10), CENTS_W'(78643200 - 600));
		send_sample(VOLT_W'(-1));
		send_load(IDX_W'(0), CENTS_W'(CENTS_PER_STEP));
		send_load(IDX_W'(10), CENTS_W'(11 * CENTS_PER_STEP));
		// extremes of the cents field, parked beyond the active notes
		send_load(IDX_W'(15), {1'b1, {(CENTS_W-1){1'b0}}});
		send_load(IDX_W'(14), {1'b0, {(CENTS_W-1){1'b1}}});
		// zero and negative period: samples give nothing
		send_load(IDX_W'(11), CENTS_W'(0));
		send_sample(VOLT_W'(5000));
		send_load(IDX_W'(11), CENTS_W'(-65536));
		send_sample(VOLT_W'(-5000));
		// smallest period: huge quotient
		send_load(IDX_W'(11), CENTS_W'(1));
		send_sample(VOLT_W'(VOLT_MAX_MAG));
		send_sample(VOLT_W'(-VOLT_MIN_MAG));
		send_load(IDX_W'(11), CENTS_W'(12 * CENTS_PER_STEP));
		drain_and_settle();

		// Random phases, one note count each: the extremes, the table edge and values beyond it.
		plan = '{2, 16, 0, 17, 1, 31, 12, 5, 3, 9};
		foreach (plan[p]) begin
			write_note_count(plan[p]);
			eff = (plan[p] > MAX_NOTES) ? MAX_NOTES : plan[p];
			gapless = ($urandom_range(0, 3) == 0);
			if (eff >= 2)
				send_load(IDX_W'(eff - 1), CENTS_W'($urandom_range(600 * 65536, 2400 * 65536)));
			// one long receiver hold-off while items keep coming
			if (p == 1)
				hold_req = 1'b1;
			repeat ((plan[p] < 2) ? 30 : 200)
				random_item(eff);
			// sender pauses here until every result has arrived
			drain_and_settle();
		end

		if (fault_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
